>>> sv/spms_pkg.sv
// shared types and codes for the shared-pool multi-stack block
`timescale 1ns / 1ps

package spms_pkg;

    localparam int OP_W     = 2;
    localparam int SID_W    = 4;
    localparam int XDATA_W  = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_TOP  = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_BAD_STACK   = 2'd1,
        ST_POOL_FULL   = 2'd2,
        ST_STACK_EMPTY = 2'd3
    } t_status;

endpackage

>>> sv/shared_pool_multi_stack_top.sv
// shared-pool multi-stack: several lifo stacks threaded through one entry pool
`timescale 1ns / 1ps

// Usage
// - input channel (i_in_valid / o_in_ready) carries one command beat: op, stack
//   number (1..NUM_STACKS) and push data
// - output channel (o_out_valid / i_out_ready) returns one result beat per
//   command: status and read data (top or popped value, zero otherwise)
// - a beat lands in an input register, executes against the pointer state and
//   the pool once the output register is free or being emptied, and its result
//   sits in the output register, which drives o_out_valid
// - one command per cycle sustained unless the receiver stalls, set by the single
//   link-memory read port: each command reads at most one link (next free entry
//   or next stack entry) and the registered read data is forwarded to the next command
// - the pool is two memories (data words and links); each stack keeps its head
//   pointer plus a cached copy of its head entry's data and link in flops
// - links of entries never pushed are not stored: a fill mark tells them apart
//   and their link is simply index + 1, so reset needs no clearing pass
// - reset empties every stack and rebuilds the free list
// - when the receiver stalls, the output register holds its beat, the input
//   register keeps one more beat and o_in_ready drops until the stall clears
module shared_pool_multi_stack_top
    import spms_pkg::*;
#(
    parameter int POOL_DEPTH = 16,
    parameter int NUM_STACKS = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [OP_W-1:0]            i_op,
    input  logic [SID_W-1:0]           i_stack_id,
    input  logic signed [XDATA_W-1:0]  i_push_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [XDATA_W-1:0]  o_read_data
);

    localparam int PW = $clog2(POOL_DEPTH + 1);              // pointer, with null
    localparam int AW = $clog2(POOL_DEPTH);                  // pool address
    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [PW-1:0] NULL_PTR = PW'(POOL_DEPTH);

    // input register
    logic                      r_in_valid;
    t_op                       r_op;
    logic [SID_W-1:0]          r_sid;
    logic signed [XDATA_W-1:0] r_push_data;

    // output register
    logic                      r_out_valid;
    t_status                   r_status;
    logic signed [XDATA_W-1:0] r_rdata;

    // pointer state
    logic [PW-1:0] r_head [NUM_STACKS];
    logic [PW-1:0] r_free_head;
    logic [PW-1:0] r_free_next;     // link of the free-list head
    logic [PW-1:0] r_fill;          // entries at or above this were never pushed
    logic          r_fn_pend;       // r_free_next arrives from the link memory
    logic          r_pend;          // head cache of r_pend_s arrives from memory
    logic [SW-1:0] r_pend_s;

    // head entry caches
    logic signed [DATA_WIDTH-1:0] r_hv [NUM_STACKS];
    logic [PW-1:0]                r_hl [NUM_STACKS];

    // pool memories
    logic signed [DATA_WIDTH-1:0] mem_val  [POOL_DEPTH];
    logic [PW-1:0]                mem_link [POOL_DEPTH];
    logic signed [DATA_WIDTH-1:0] mem_val_q;
    logic [PW-1:0]                mem_link_q;

    // execute stage
    logic                         exec_fire;
    logic                         sid_ok;
    logic [SW-1:0]                s_idx;
    logic [PW-1:0]                head;
    logic signed [DATA_WIDTH-1:0] hv_eff;
    logic [PW-1:0]                hl_eff;
    logic [PW-1:0]                fn_eff;
    logic [PW-1:0]                fill_new;
    logic                         fn_untouched;
    logic                         do_push;
    logic                         do_pop;
    t_status                      n_status;
    logic signed [XDATA_W-1:0]    n_rdata;
    logic [AW-1:0]                link_ra;
    logic [AW-1:0]                link_wa;
    logic [PW-1:0]                link_wd;

    assign exec_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec_fire;

    always_comb begin
        sid_ok   = (r_sid != '0) && (r_sid <= SID_W'(NUM_STACKS));
        s_idx    = SW'(r_sid - SID_W'(1));
        head     = r_head[s_idx];
        // forward a head fetch still in the memory output register
        hv_eff   = (r_pend && (r_pend_s == s_idx)) ? mem_val_q  : r_hv[s_idx];
        hl_eff   = (r_pend && (r_pend_s == s_idx)) ? mem_link_q : r_hl[s_idx];
        fn_eff   = r_fn_pend ? mem_link_q : r_free_next;
        fill_new = (r_free_head >= r_fill) ? (r_free_head + PW'(1)) : r_fill;
        fn_untouched = (fn_eff >= fill_new);

        n_status = ST_OK;
        n_rdata  = '0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        if (r_op == OP_NOP) begin
            n_status = ST_OK;
        end else if (!sid_ok) begin
            n_status = ST_BAD_STACK;
        end else if (r_op == OP_PUSH) begin
            if (r_free_head == NULL_PTR) begin
                n_status = ST_POOL_FULL;
            end else begin
                do_push = 1'b1;
            end
        end else if (head == NULL_PTR) begin
            n_status = ST_STACK_EMPTY;
        end else begin
            n_rdata = XDATA_W'(hv_eff);
            do_pop  = (r_op == OP_POP);
        end

        // one link read: next free entry on push, next stack entry otherwise
        link_ra = do_push ? fn_eff[AW-1:0] : hl_eff[AW-1:0];
        link_wa = do_push ? r_free_head[AW-1:0] : head[AW-1:0];
        link_wd = do_push ? head : r_free_head;
    end

    // pool memories, registered read
    always_ff @(posedge i_clk) begin
        if (exec_fire && do_push) begin
            mem_val[r_free_head[AW-1:0]] <= DATA_WIDTH'(r_push_data);
        end
        if (exec_fire && (do_push || do_pop)) begin
            mem_link[link_wa] <= link_wd;
        end
        mem_val_q  <= mem_val[hl_eff[AW-1:0]];
        mem_link_q <= mem_link[link_ra];
    end

    // control and pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_free_head <= '0;
            r_free_next <= PW'(1);
            r_fill      <= '0;
            r_fn_pend   <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_s    <= '0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_head[i] <= NULL_PTR;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end

            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // retire last cycle's fetch, current command may override
            r_fn_pend <= 1'b0;
            r_pend    <= 1'b0;
            if (r_fn_pend) begin
                r_free_next <= mem_link_q;
            end

            if (exec_fire && do_push) begin
                r_head[s_idx] <= r_free_head;
                r_free_head   <= fn_eff;
                r_fill        <= fill_new;
                if (fn_untouched) begin
                    r_free_next <= PW'(fn_eff + PW'(1));
                end else begin
                    r_fn_pend <= 1'b1;
                end
            end

            if (exec_fire && do_pop) begin
                r_head[s_idx] <= hl_eff;
                r_free_head   <= head;
                r_free_next   <= r_free_head;
                r_pend        <= (hl_eff != NULL_PTR);
                r_pend_s      <= s_idx;
            end
        end
    end

    // payload registers and head caches
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op        <= t_op'(i_op);
            r_sid       <= i_stack_id;
            r_push_data <= i_push_data;
        end
        if (exec_fire) begin
            r_status <= n_status;
            r_rdata  <= n_rdata;
        end
        if (r_pend) begin
            r_hv[r_pend_s] <= mem_val_q;
            r_hl[r_pend_s] <= mem_link_q;
        end
        if (exec_fire && do_push) begin
            r_hv[s_idx] <= DATA_WIDTH'(r_push_data);
            r_hl[s_idx] <= head;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_read_data = r_rdata;

    // only one link fetch can be in flight
    a_one_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && r_fn_pend))
        else $error("free-next and head fetch in flight together");

    // free-list head is a pushed entry, the first never-pushed one, or null
    a_free_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head <= r_fill) && (r_fill <= NULL_PTR))
        else $error("free-list head beyond fill mark");

    // a successful push returns ok with zero data in the next output beat
    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire && do_push |=> o_out_valid && (o_status == ST_OK) && (o_read_data == '0))
        else $error("push result beat wrong");

    // a pop hands its entry back to the free list
    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire && do_pop |=> (r_free_head == $past(head)) && !r_fn_pend)
        else $error("popped entry not at free-list head");

endmodule
